[design/qbez_pkg.sv]
// Shared types, constants and tables for the quintic Bezier evaluator.
// No dependencies; every other file of the block depends on this package.
package qbez_pkg;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int T_W        = 17;
    localparam int T_FRAC     = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 16;
    localparam int RES_W      = 32;
    localparam int NUM_POINTS = 6;
    localparam int LANE_W     = 3;
    localparam int NUM_PAIRS  = NUM_POINTS / 2;
    localparam int NUM_AXES   = 2;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;

    // Default fraction width of the internal parameter arithmetic
    localparam int FRAC_BITS_DEF = 16;

    // Arithmetic widths beyond the fraction
    localparam int COEF_W    = 7;   // largest basis coefficient is 60
    localparam int DIFF_W    = 18;  // second difference of 16-bit points
    localparam int ACC_GUARD = 28;  // integer bits of the weighted sum

    // Pipeline layout: powers, weights, accumulate
    localparam int POW_STAGES = 5;
    localparam int WGT_STAGES = 2;
    localparam int ACC_STAGES = 3;
    localparam int WGT_FIRST  = POW_STAGES;
    localparam int ACC_FIRST  = WGT_FIRST + WGT_STAGES;
    localparam int STAGES     = ACC_FIRST + ACC_STAGES;

    // One in unsigned Q1.16
    localparam logic [T_W-1:0] T_ONE_Q16 = T_W'(1) << T_FRAC;

    // Result range
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT5 = 3'd5;

    // Result selection
    typedef enum logic [KIND_W-1:0] {
        KIND_POINT = 2'd0,
        KIND_D1    = 2'd1,
        KIND_D2    = 2'd2
    } t_kind;

    // Control points, [axis][point]
    typedef logic [NUM_AXES-1:0][NUM_POINTS-1:0][COORD_W-1:0] t_point_set;

    // Basis coefficients per lane, zero past the last lane of each degree
    localparam logic [COEF_W-1:0] COEF_PT [NUM_POINTS] =
        '{7'd1, 7'd5, 7'd10, 7'd10, 7'd5, 7'd1};
    localparam logic [COEF_W-1:0] COEF_D1 [NUM_POINTS] =
        '{7'd5, 7'd20, 7'd30, 7'd20, 7'd5, 7'd0};
    localparam logic [COEF_W-1:0] COEF_D2 [NUM_POINTS] =
        '{7'd20, 7'd60, 7'd60, 7'd20, 7'd0, 7'd0};

    function automatic logic [COEF_W-1:0] coef_of(input logic [KIND_W-1:0] kind,
                                                  input logic [LANE_W-1:0] lane);
        logic [COEF_W-1:0] c;
        c = '0;
        case (kind)
            KIND_POINT: c = COEF_PT[lane];
            KIND_D1:    c = COEF_D1[lane];
            KIND_D2:    c = COEF_D2[lane];
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

[design/qbez_if.sv]
// Valid/ready channel interfaces for the evaluator: request items and results.
// Depends on qbez_pkg for field widths.
interface qbez_item_if;
    import qbez_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [T_W-1:0]    param_t;

    modport source (output valid, kind, param_t, input ready);
    modport sink   (input valid, kind, param_t, output ready);
endinterface

interface qbez_result_if;
    import qbez_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_x;
    logic signed [RES_W-1:0] result_y;
    logic                    saturated;

    modport source (output valid, result_x, result_y, saturated, input ready);
    modport sink   (input valid, result_x, result_y, saturated, output ready);
endinterface

[design/qbez_qmul.sv]
// Unsigned Q1.F product rounded half up, for operands at most one.
// Depends on qbez_pkg for the default fraction width.
module qbez_qmul #(
    parameter int FRAC_BITS = qbez_pkg::FRAC_BITS_DEF
) (
    input  logic [FRAC_BITS:0] i_a,
    input  logic [FRAC_BITS:0] i_b,
    output logic [FRAC_BITS:0] o_p
);
    localparam int QW = FRAC_BITS + 1;
    localparam logic [2*QW-1:0] HALF = (2*QW)'(1) << (FRAC_BITS - 1);

    logic [2*QW-1:0] w_prod;

    // Multiply, round, drop the fraction; the result never exceeds one
    assign w_prod = (2*QW)'(i_a) * (2*QW)'(i_b) + HALF;
    assign o_p    = w_prod[2*FRAC_BITS:FRAC_BITS];
endmodule

[design/qbez_cfg_regs.sv]
// Control point registers written through the plain configuration port.
// Depends on qbez_pkg for register indexes and the point set type.
module qbez_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [qbez_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [qbez_pkg::CFG_W-1:0]     i_data,
    output qbez_pkg::t_point_set           o_pts
);
    import qbez_pkg::*;

    logic [NUM_POINTS-1:0][CFG_W-1:0] r_pt;

    // Write the addressed point; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= '0;
        end else if (i_we) begin
            unique case (i_idx)
                REG_POINT0: r_pt[0] <= i_data;
                REG_POINT1: r_pt[1] <= i_data;
                REG_POINT2: r_pt[2] <= i_data;
                REG_POINT3: r_pt[3] <= i_data;
                REG_POINT4: r_pt[4] <= i_data;
                REG_POINT5: r_pt[5] <= i_data;
                default: ;
            endcase
        end
    end

    // Split each register into x (upper half) and y (lower half)
    always_comb begin
        for (int k = 0; k < NUM_POINTS; k++) begin
            o_pts[AXIS_X][k] = r_pt[k][CFG_W-1:COORD_W];
            o_pts[AXIS_Y][k] = r_pt[k][COORD_W-1:0];
        end
    end
endmodule

[design/qbez_powers.sv]
// Input stage and power chain: t and 1-t, then t^k and (1-t)^k, one power per stage.
// Depends on qbez_pkg and qbez_qmul.
module qbez_powers #(
    parameter int FRAC_BITS = qbez_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic [qbez_pkg::POW_STAGES-1:0]             i_en,
    input  logic [qbez_pkg::KIND_W-1:0]                 i_kind,
    input  logic [qbez_pkg::T_W-1:0]                    i_param_t,
    output logic [qbez_pkg::KIND_W-1:0]                 o_kind,
    output logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS:0] o_tp,
    output logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS:0] o_up
);
    import qbez_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    typedef logic [NUM_POINTS-1:0][QW-1:0] t_pow_vec;

    logic [T_W-1:0]    w_t_clip;
    logic [QW-1:0]     w_tf;
    t_pow_vec          n_tp0;
    t_pow_vec          n_up0;
    t_pow_vec          r_tp   [POW_STAGES];
    t_pow_vec          r_up   [POW_STAGES];
    logic [KIND_W-1:0] r_kind [POW_STAGES];

    // Clamp t to one, then bring it to the internal fraction width
    assign w_t_clip = (i_param_t > T_ONE_Q16) ? T_ONE_Q16 : i_param_t;

    if (FRAC_BITS >= T_FRAC) begin : g_widen
        assign w_tf = QW'(w_t_clip) << (FRAC_BITS - T_FRAC);
    end else begin : g_narrow
        localparam int SH = T_FRAC - FRAC_BITS;
        logic [T_W:0] w_t_sum;
        assign w_t_sum = {1'b0, w_t_clip} + ((T_W + 1)'(1) << (SH - 1));
        assign w_tf    = QW'(w_t_sum >> SH);
    end

    // First stage holds the zeroth and first powers
    always_comb begin
        n_tp0    = '0;
        n_up0    = '0;
        n_tp0[0] = ONE;
        n_up0[0] = ONE;
        n_tp0[1] = w_tf;
        n_up0[1] = ONE - w_tf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_tp[0]   <= n_tp0;
            r_up[0]   <= n_up0;
            r_kind[0] <= i_kind;
        end
    end

    // Each later stage adds the next power from the previous one times t or 1-t
    for (genvar s = 1; s < POW_STAGES; s++) begin : g_pow
        logic [QW-1:0] w_tn;
        logic [QW-1:0] w_un;
        t_pow_vec      n_tp;
        t_pow_vec      n_up;

        qbez_qmul #(.FRAC_BITS(FRAC_BITS)) u_tmul (
            .i_a (r_tp[s-1][s]),
            .i_b (r_tp[s-1][1]),
            .o_p (w_tn)
        );

        qbez_qmul #(.FRAC_BITS(FRAC_BITS)) u_umul (
            .i_a (r_up[s-1][s]),
            .i_b (r_up[s-1][1]),
            .o_p (w_un)
        );

        always_comb begin
            n_tp      = r_tp[s-1];
            n_up      = r_up[s-1];
            n_tp[s+1] = w_tn;
            n_up[s+1] = w_un;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_tp[s]   <= n_tp;
                r_up[s]   <= n_up;
                r_kind[s] <= r_kind[s-1];
            end
        end
    end

    assign o_kind = r_kind[POW_STAGES-1];
    assign o_tp   = r_tp[POW_STAGES-1];
    assign o_up   = r_up[POW_STAGES-1];
endmodule

[design/qbez_weights.sv]
// Basis weights: rounded t^k (1-t)^(n-k) per lane, then scaled by the coefficient.
// Depends on qbez_pkg and qbez_qmul.
module qbez_weights #(
    parameter int FRAC_BITS = qbez_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic [qbez_pkg::WGT_STAGES-1:0]              i_en,
    input  logic [qbez_pkg::KIND_W-1:0]                  i_kind,
    input  logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS:0] i_tp,
    input  logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS:0] i_up,
    output logic [qbez_pkg::KIND_W-1:0]                  o_kind,
    output logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS+qbez_pkg::COEF_W-1:0] o_cw
);
    import qbez_pkg::*;

    localparam int QW   = FRAC_BITS + 1;
    localparam int CW_W = FRAC_BITS + COEF_W;

    logic [NUM_POINTS-1:0][QW-1:0]   r_w;
    logic [NUM_POINTS-1:0][CW_W-1:0] n_cw;
    logic [NUM_POINTS-1:0][CW_W-1:0] r_cw;
    logic [KIND_W-1:0]               r_kind_w;
    logic [KIND_W-1:0]               r_kind_cw;

    // Pick the (1-t) power for each lane by degree; unused lanes get zero
    for (genvar k = 0; k < NUM_POINTS; k++) begin : g_lane
        localparam int I0 = NUM_POINTS - 1 - k;
        localparam int I1 = (k < NUM_POINTS - 1) ? NUM_POINTS - 2 - k : 0;
        localparam int I2 = (k < NUM_POINTS - 2) ? NUM_POINTS - 3 - k : 0;

        logic [QW-1:0] w_b;
        logic [QW-1:0] w_p;

        always_comb begin
            unique case (i_kind)
                KIND_POINT: w_b = i_up[I0];
                KIND_D1:    w_b = (k < NUM_POINTS - 1) ? i_up[I1] : '0;
                KIND_D2:    w_b = (k < NUM_POINTS - 2) ? i_up[I2] : '0;
                default:    w_b = '0;
            endcase
        end

        qbez_qmul #(.FRAC_BITS(FRAC_BITS)) u_wmul (
            .i_a (i_tp[k]),
            .i_b (w_b),
            .o_p (w_p)
        );

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_w[k] <= w_p;
            end
        end

        // Scale by the small integer coefficient
        assign n_cw[k] = CW_W'(r_w[k]) * CW_W'(coef_of(r_kind_w, LANE_W'(k)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_kind_w <= i_kind;
        end
        if (i_en[1]) begin
            r_cw      <= n_cw;
            r_kind_cw <= r_kind_w;
        end
    end

    assign o_kind = r_kind_cw;
    assign o_cw   = r_cw;
endmodule

[design/qbez_accum.sv]
// Point differences times weights, pairwise sums, final sum with rounding and clipping.
// Depends on qbez_pkg.
module qbez_accum #(
    parameter int FRAC_BITS = qbez_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [qbez_pkg::ACC_STAGES-1:0]     i_en,
    input  logic [qbez_pkg::KIND_W-1:0]         i_kind,
    input  logic [qbez_pkg::NUM_POINTS-1:0][FRAC_BITS+qbez_pkg::COEF_W-1:0] i_cw,
    input  qbez_pkg::t_point_set                i_pts,
    output logic signed [qbez_pkg::RES_W-1:0]   o_result_x,
    output logic signed [qbez_pkg::RES_W-1:0]   o_result_y,
    output logic                                o_saturated
);
    import qbez_pkg::*;

    localparam int CW_W   = FRAC_BITS + COEF_W;
    localparam int ACC_W  = FRAC_BITS + ACC_GUARD;
    localparam int PROD_W = CW_W + 1 + DIFF_W;
    localparam int EXT_W  = RES_W + 2;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'(RES_MAX);
    localparam logic signed [EXT_W-1:0] LIM_LO = EXT_W'(RES_MIN);

    logic signed [ACC_W-1:0] r_term [NUM_AXES][NUM_POINTS];
    logic signed [ACC_W-1:0] r_pair [NUM_AXES][NUM_PAIRS];
    logic signed [RES_W-1:0] n_res  [NUM_AXES];
    logic signed [RES_W-1:0] r_res  [NUM_AXES];
    logic                    n_sat;
    logic                    r_sat;

    // Per axis and lane: select the difference for the kind, multiply by the weight
    for (genvar c = 0; c < NUM_AXES; c++) begin : g_axis
        for (genvar k = 0; k < NUM_POINTS; k++) begin : g_lane
            localparam int K1 = (k < NUM_POINTS - 1) ? k + 1 : k;
            localparam int K2 = (k < NUM_POINTS - 2) ? k + 2 : k;

            logic signed [DIFF_W-1:0] w_p0;
            logic signed [DIFF_W-1:0] w_p1;
            logic signed [DIFF_W-1:0] w_p2;
            logic signed [DIFF_W-1:0] w_d;
            logic signed [PROD_W-1:0] w_prod;

            assign w_p0 = DIFF_W'($signed(i_pts[c][k]));
            assign w_p1 = DIFF_W'($signed(i_pts[c][K1]));
            assign w_p2 = DIFF_W'($signed(i_pts[c][K2]));

            always_comb begin
                unique case (i_kind)
                    KIND_POINT: w_d = w_p0;
                    KIND_D1:    w_d = (k < NUM_POINTS - 1) ? w_p1 - w_p0 : '0;
                    KIND_D2:    w_d = (k < NUM_POINTS - 2) ?
                                      w_p0 - (w_p1 <<< 1) + w_p2 : '0;
                    default:    w_d = '0;
                endcase
            end

            assign w_prod = $signed({1'b0, i_cw[k]}) * w_d;

            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_term[c][k] <= ACC_W'(w_prod);
                end
            end
        end

        // Reduce six terms to three pair sums
        for (genvar j = 0; j < NUM_PAIRS; j++) begin : g_pair
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    r_pair[c][j] <= r_term[c][2*j] + r_term[c][2*j+1];
                end
            end
        end
    end

    // Final sum, round half up by an arithmetic shift, clip to the result range
    always_comb begin
        logic signed [ACC_W-1:0]     acc;
        logic signed [ACC_GUARD-1:0] q;
        logic signed [EXT_W-1:0]     q_ext;
        n_sat = 1'b0;
        for (int c = 0; c < NUM_AXES; c++) begin
            acc   = r_pair[c][0] + r_pair[c][1] + r_pair[c][2] + HALF;
            q     = ACC_GUARD'(acc >>> FRAC_BITS);
            q_ext = EXT_W'(q);
            if (q_ext > LIM_HI) begin
                n_res[c] = RES_MAX;
                n_sat    = 1'b1;
            end else if (q_ext < LIM_LO) begin
                n_res[c] = RES_MIN;
                n_sat    = 1'b1;
            end else begin
                n_res[c] = RES_W'(q_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_result_x  = r_res[AXIS_X];
    assign o_result_y  = r_res[AXIS_Y];
    assign o_saturated = r_sat;
endmodule

[design/quintic_bezier_evaluator.sv]
// Top level of the quintic Bezier evaluator: stage valids, stall chain, submodules.
// Depends on qbez_pkg, qbez_if, qbez_cfg_regs, qbez_powers, qbez_weights, qbez_accum.
//
//  channel    direction  handshake        payload
//  i_item     in         valid / ready    kind[1:0], param_t[16:0]
//  o_result   out        valid / ready    result_x[31:0], result_y[31:0], saturated
//  i_cfg_*    in         write enable     i_cfg_idx[2:0], i_cfg_data[31:0]
//
// One transaction per cycle sustained while the result side is ready; ten register stages.
// Stages: t and 1-t, t^2..t^5 (one rounded product each), weight, coefficient, point-term,
// pair-sum and final round/clip.
// Synchronous active-low reset clears the stage valids and the control points.
// A stalled result holds every full stage behind it while bubbles still close up;
// the input stalls only once all ten stages hold a transaction.
module quintic_bezier_evaluator #(
    parameter int FRAC_BITS = qbez_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [qbez_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qbez_pkg::CFG_W-1:0]     i_cfg_data,
    qbez_item_if.sink                      i_item,
    qbez_result_if.source                  o_result
);
    import qbez_pkg::*;

    localparam int CW_W = FRAC_BITS + COEF_W;

    logic [STAGES-1:0]                      w_en;
    logic [STAGES-1:0]                      r_valid;
    t_point_set                             w_pts;
    logic [KIND_W-1:0]                      w_pow_kind;
    logic [NUM_POINTS-1:0][FRAC_BITS:0]     w_tp;
    logic [NUM_POINTS-1:0][FRAC_BITS:0]     w_up;
    logic [KIND_W-1:0]                      w_wgt_kind;
    logic [NUM_POINTS-1:0][CW_W-1:0]        w_cw;

    // Stage advances when empty or when the stage after it advances
    always_comb begin
        w_en[STAGES-1] = !r_valid[STAGES-1] || o_result.ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_valid[s] || w_en[s+1];
        end
    end

    // Move valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_item.valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (w_en[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    assign i_item.ready   = w_en[0];
    assign o_result.valid = r_valid[STAGES-1];

    qbez_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_pts   (w_pts)
    );

    qbez_powers #(.FRAC_BITS(FRAC_BITS)) u_powers (
        .i_clk     (i_clk),
        .i_en      (w_en[POW_STAGES-1:0]),
        .i_kind    (i_item.kind),
        .i_param_t (i_item.param_t),
        .o_kind    (w_pow_kind),
        .o_tp      (w_tp),
        .o_up      (w_up)
    );

    qbez_weights #(.FRAC_BITS(FRAC_BITS)) u_weights (
        .i_clk  (i_clk),
        .i_en   (w_en[ACC_FIRST-1:WGT_FIRST]),
        .i_kind (w_pow_kind),
        .i_tp   (w_tp),
        .i_up   (w_up),
        .o_kind (w_wgt_kind),
        .o_cw   (w_cw)
    );

    qbez_accum #(.FRAC_BITS(FRAC_BITS)) u_accum (
        .i_clk       (i_clk),
        .i_en        (w_en[STAGES-1:ACC_FIRST]),
        .i_kind      (w_wgt_kind),
        .i_cw        (w_cw),
        .i_pts       (w_pts),
        .o_result_x  (o_result.result_x),
        .o_result_y  (o_result.result_y),
        .o_saturated (o_result.saturated)
    );

    // An accepted transaction occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_valid[0])
        else $error("accepted transaction did not enter the pipeline");

    // A stalled item in the middle of the pipeline is not dropped
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[ACC_FIRST] && !w_en[ACC_FIRST]) |=> r_valid[ACC_FIRST])
        else $error("stalled stage lost its item");

    // A clipped result sits at a bound of the range
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.saturated) |->
        (o_result.result_x == RES_MAX || o_result.result_x == RES_MIN ||
         o_result.result_y == RES_MAX || o_result.result_y == RES_MIN))
        else $error("saturated flag without a clipped result");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
endmodule

[dv/testbench.sv]
// Self-checking bench for quintic_bezier_evaluator: random and directed curve evaluations.
// Depends on qbez_pkg and the qbez_if channel interfaces; holds its own fixed-point predictor.
module testbench;
    import qbez_pkg::*;

    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES   = STAGES + 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    // Code of the kind outside the defined kinds; its result is zero
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic signed [RES_W-1:0] x;
        logic signed [RES_W-1:0] y;
        logic                    sat;
    } t_bez_result;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    qbez_item_if   item_ch ();
    qbez_result_if result_ch ();

    quintic_bezier_evaluator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // Predictor copy of the control points
    logic [CFG_W-1:0] ctrl_pts [NUM_POINTS];

    t_bez_result pending_results [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          hold_req       = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Rounded Q1.F product
    function automatic longint unsigned round_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << (FRAC - 1))) >> FRAC;
    endfunction

    function automatic longint blend_coef(logic [KIND_W-1:0] kind, int k);
        case (kind)
            KIND_POINT: case (k)
                0, 5:    return 1;
                1, 4:    return 5;
                default: return 10;
            endcase
            KIND_D1: case (k)
                0, 4:    return 5;
                1, 3:    return 20;
                default: return 30;
            endcase
            KIND_D2: case (k)
                0, 3:    return 20;
                default: return 60;
            endcase
            default: return 0;
        endcase
    endfunction

    // Expected point or derivative for one parameter value
    function automatic t_bez_result eval_curve(logic [KIND_W-1:0] kind, logic [T_W-1:0] t_in);
        longint unsigned one, tf, uf;
        longint unsigned tp [6];
        longint unsigned up [6];
        longint          px [NUM_POINTS];
        longint          py [NUM_POINTS];
        longint          acc [NUM_AXES];
        longint          w, q;
        logic [T_W-1:0]  t_c;
        t_bez_result     r;
        int              k, a;
        one      = 64'd1 << FRAC;
        t_c      = (t_in > T_ONE_Q16) ? T_ONE_Q16 : t_in;
        tf       = longint'(t_c) << (FRAC - T_FRAC);
        uf       = one - tf;
        tp[0]    = one;
        up[0]    = one;
        acc[0]   = 0;
        acc[1]   = 0;
        r.x      = '0;
        r.y      = '0;
        r.sat    = 1'b0;
        for (k = 1; k < 6; k++) begin
            tp[k] = round_mul(tp[k-1], tf);
            up[k] = round_mul(up[k-1], uf);
        end
        for (k = 0; k < NUM_POINTS; k++) begin
            px[k] = $signed(ctrl_pts[k][31:16]);
            py[k] = $signed(ctrl_pts[k][15:0]);
        end
        case (kind)
            KIND_POINT: for (k = 0; k < 6; k++) begin
                w = blend_coef(kind, k) * longint'(round_mul(tp[k], up[5-k]));
                acc[AXIS_X] += w * px[k];
                acc[AXIS_Y] += w * py[k];
            end
            KIND_D1: for (k = 0; k < 5; k++) begin
                w = blend_coef(kind, k) * longint'(round_mul(tp[k], up[4-k]));
                acc[AXIS_X] += w * (px[k+1] - px[k]);
                acc[AXIS_Y] += w * (py[k+1] - py[k]);
            end
            KIND_D2: for (k = 0; k < 4; k++) begin
                w = blend_coef(kind, k) * longint'(round_mul(tp[k], up[3-k]));
                acc[AXIS_X] += w * (px[k] - 2 * px[k+1] + px[k+2]);
                acc[AXIS_Y] += w * (py[k] - 2 * py[k+1] + py[k+2]);
            end
            default: ;
        endcase
        if (kind != KIND_UNUSED) begin
            // Round half up, then clip to 32 bits
            for (a = 0; a < NUM_AXES; a++) begin
                q = (acc[a] + (64'sd1 << (FRAC - 1))) >>> FRAC;
                if (q > longint'(RES_MAX)) begin
                    q     = longint'(RES_MAX);
                    r.sat = 1'b1;
                end
                if (q < longint'(RES_MIN)) begin
                    q     = longint'(RES_MIN);
                    r.sat = 1'b1;
                end
                if (a == AXIS_X) r.x = q[RES_W-1:0];
                else             r.y = q[RES_W-1:0];
            end
        end
        return r;
    endfunction

    // Offer one item after a random gap and record its expected result
    task automatic send_item(logic [KIND_W-1:0] kind, logic [T_W-1:0] t);
        int gap;
        @(negedge clk);
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= kind;
        item_ch.param_t <= t;
        do @(posedge clk); while (!item_ch.ready);
        pending_results.push_back(eval_curve(kind, t));
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty
    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_point(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        ctrl_pts[idx] = data;
    endtask

    // Load all six control points while the block is idle
    task automatic set_points(logic [CFG_W-1:0] p0, logic [CFG_W-1:0] p1,
                              logic [CFG_W-1:0] p2, logic [CFG_W-1:0] p3,
                              logic [CFG_W-1:0] p4, logic [CFG_W-1:0] p5);
        wait_drained();
        write_point(REG_POINT0, p0);
        write_point(REG_POINT1, p1);
        write_point(REG_POINT2, p2);
        write_point(REG_POINT3, p3);
        write_point(REG_POINT4, p4);
        write_point(REG_POINT5, p5);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One coordinate, often at an extreme
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_point();
        return {pick_coord(), pick_coord()};
    endfunction

    task automatic send_random_item();
        logic [KIND_W-1:0] kind;
        logic [T_W-1:0]    t;
        int                r;
        r = $urandom_range(0, 15);
        if (r < 5)       kind = KIND_POINT;
        else if (r < 10) kind = KIND_D1;
        else if (r < 15) kind = KIND_D2;
        else             kind = KIND_UNUSED;
        case ($urandom_range(0, 9))
            0:       t = T_W'($urandom_range(0, 131071));
            1: case ($urandom_range(0, 3))
                0:       t = '0;
                1:       t = T_ONE_Q16;
                2:       t = 17'd1;
                default: t = T_ONE_Q16 - 17'd1;
            endcase
            default: t = T_W'($urandom_range(0, 65536));
        endcase
        send_item(kind, t);
    endtask

    // Reset values: every point at zero gives zero everywhere
    task automatic test_after_reset();
        send_item(KIND_POINT, '0);
        send_item(KIND_POINT, T_ONE_Q16);
        send_item(KIND_D1, 17'd40000);
        send_item(KIND_D2, 17'd12345);
        send_item(KIND_UNUSED, 17'd131071);
    endtask

    // Extremes of the points and of t, every kind, t beyond one, unused kind
    task automatic test_directed();
        set_points(32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000,
                   32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF);
        send_item(KIND_POINT, '0);
        send_item(KIND_POINT, T_ONE_Q16);
        send_item(KIND_POINT, 17'd32768);
        send_item(KIND_D1, '0);
        send_item(KIND_D1, T_ONE_Q16);
        send_item(KIND_D1, 17'd32768);
        send_item(KIND_D2, '0);
        send_item(KIND_D2, T_ONE_Q16);
        send_item(KIND_D2, 17'd32768);
        send_item(KIND_POINT, 17'd1);
        send_item(KIND_D2, T_ONE_Q16 - 17'd1);
        send_item(KIND_POINT, T_ONE_Q16 + 17'd1);
        send_item(KIND_D1, 17'h1FFFF);
        send_item(KIND_UNUSED, '0);
        send_item(KIND_UNUSED, T_ONE_Q16);
        set_points(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                   32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_item(KIND_POINT, 17'd21845);
        send_item(KIND_D1, 17'd21845);
        send_item(KIND_D2, 17'd21845);
        send_item(KIND_POINT, T_ONE_Q16);
        send_item(KIND_D1, 17'd65000);
        send_item(KIND_D2, 17'd500);
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_back_pressure();
        int i;
        set_points(pick_point(), pick_point(), pick_point(),
                   pick_point(), pick_point(), pick_point());
        tx_idle_en = 1'b0;
        hold_req   = HOLD_CYCLES;
        for (i = 0; i < 40; i++) send_random_item();
        tx_idle_en = 1'b1;
    endtask

    // Random settings, each with a burst of random items; idling toggled per setting
    task automatic test_random_curves();
        int s, i;
        for (s = 0; s < 7; s++) begin
            set_points(pick_point(), pick_point(), pick_point(),
                       pick_point(), pick_point(), pick_point());
            tx_idle_en = (s % 3) != 1;
            rx_idle_en = (s % 3) != 2;
            for (i = 0; i < 55; i++) send_random_item();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Stimulus and final verdict
    initial begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_POINT0;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.kind    <= KIND_POINT;
        item_ch.param_t <= '0;
        for (int k = 0; k < NUM_POINTS; k++) ctrl_pts[k] = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_directed();
        test_back_pressure();
        test_random_curves();
        wait_drained();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** quintic_bezier_evaluator: PASSED **");
        end else begin
            $display("** quintic_bezier_evaluator: FAILED **");
        end
        $finish;
    end

    // Result sink: random stalls, one long hold on request, compare each transaction
    initial begin : result_sink
        int          gap;
        int          hold;
        t_bez_result want;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                hold     = hold_req;
                hold_req = 0;
                result_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end else begin
                gap = rx_idle_en ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h sat=%b", $time,
                         result_ch.result_x, result_ch.result_y, result_ch.saturated);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_ch.result_x !== want.x) begin
                    $display("%0t: result_x expected %h actual %h", $time,
                             want.x, result_ch.result_x);
                    mismatch_count++;
                end
                if (result_ch.result_y !== want.y) begin
                    $display("%0t: result_y expected %h actual %h", $time,
                             want.y, result_ch.result_y);
                    mismatch_count++;
                end
                if (result_ch.saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, result_ch.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d results outstanding", $time,
                     pending_results.size());
            $display("** quintic_bezier_evaluator: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
